[sv/bps_pkg.sv]
package bps_pkg;

  localparam int HEIGHT_W = 32;
  localparam int FRAME_W  = 16;
  localparam int RATIO_W  = 17;
  localparam int REST_W   = 17;
  localparam int GRAV_W   = 16;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // config register map, byte address = 4 * index
  typedef enum logic [1:0] {
    REG_RESTITUTION = 2'd0,
    REG_BASE_GRAVITY = 2'd1,
    REG_FADE_START = 2'd2,
    REG_FADE_END = 2'd3
  } reg_idx_t;

  localparam logic [REST_W-1:0]  RESTITUTION_RST = 17'd53248;
  localparam logic [GRAV_W-1:0]  BASE_GRAVITY_RST = 16'd3211;
  localparam logic [FRAME_W-1:0] FADE_START_RST = 16'd1900;
  localparam logic [FRAME_W-1:0] FADE_END_RST = 16'd2000;

  // x / 200 = (x >> 3) / 25; floor(2^35 / 25) undershoots by at most one
  localparam logic [30:0] RECIP25 = 31'd1374389534;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    logic signed [31:0] r;
    if (x > 52'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -52'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[sv/bps_in_if.sv]
interface bps_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bps_pkg::HEIGHT_W-1:0]  height;
  logic signed [bps_pkg::HEIGHT_W-1:0]  velocity;
  logic [bps_pkg::FRAME_W-1:0]          frame_number;
  logic [bps_pkg::RATIO_W-1:0]          time_ratio;

  modport source(output valid, height, velocity, frame_number, time_ratio, input ready);
  modport sink(input valid, height, velocity, frame_number, time_ratio, output ready);
endinterface

[sv/bps_out_if.sv]
interface bps_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bps_pkg::HEIGHT_W-1:0]  new_height;
  logic signed [bps_pkg::HEIGHT_W-1:0]  new_velocity;
  logic                                 bounced;

  modport source(output valid, new_height, new_velocity, bounced, input ready);
  modport sink(input valid, new_height, new_velocity, bounced, output ready);
endinterface

[sv/bps_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Expects rem < den; quotient is the QBITS-bit fraction (rem << QBITS) / den.
module bps_div #(
  parameter int DEN_W  = 16,
  parameter int QBITS  = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [QBITS-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic [QBITS-1:0]  valid;
  logic [QBITS:0]    rdy;
  logic [DEN_W-1:0]  rem  [QBITS];
  logic [DEN_W-1:0]  den  [QBITS];
  logic [QBITS-1:0]  quo  [QBITS];
  logic [SIDE_W-1:0] side [QBITS];

  assign rdy[QBITS] = out_ready;
  assign in_ready   = rdy[0];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic              p_valid;
    logic [DEN_W-1:0]  p_rem;
    logic [DEN_W-1:0]  p_den;
    logic [QBITS-1:0]  p_quo;
    logic [SIDE_W-1:0] p_side;
    logic [DEN_W:0]    dbl;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign p_valid = in_valid;
      assign p_rem   = in_rem;
      assign p_den   = in_den;
      assign p_quo   = '0;
      assign p_side  = in_side;
    end else begin : g_next
      assign p_valid = valid[k-1];
      assign p_rem   = rem[k-1];
      assign p_den   = den[k-1];
      assign p_quo   = quo[k-1];
      assign p_side  = side[k-1];
    end

    assign dbl    = {p_rem, 1'b0};
    assign diff   = dbl - {1'b0, p_den};
    assign ge     = dbl >= {1'b0, p_den};
    assign rdy[k] = !valid[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid[k] <= p_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem[k]  <= ge ? diff[DEN_W-1:0] : dbl[DEN_W-1:0];
        den[k]  <= p_den;
        quo[k]  <= {p_quo[QBITS-2:0], ge};
        side[k] <= p_side;
      end
    end
  end

  assign out_valid = valid[QBITS-1];
  assign out_quo   = quo[QBITS-1];
  assign out_side  = side[QBITS-1];

endmodule

[sv/bouncing_particle_step_core.sv]
// Particle step core: advances one particle's height and vertical velocity
// over a fraction of a frame, with a gravity fade and a ground bounce.
//
// item   (sink):   height, velocity, frame_number, time_ratio. A word is
//                  taken when valid and ready are both high.
// result (source): new_height, new_velocity, bounced, one word per item,
//                  in order.
// APB port: restitution, base_gravity, fade_start_frame, fade_end_frame at
//   byte addresses 0, 4, 8, 12; write only while the core is idle.
//
// Pipeline: one input stage, FRAC_BITS stages of the fade divider, six
// arithmetic stages, FRAC_BITS stages of the impact-fraction divider,
// three output stages. One word per cycle sustained while result.ready
// is high. Each stage holds only when the stage behind it is full and
// stalled, so empty slots close up while the receiver stalls and
// item.ready stays high until the whole pipe is full.
// Reset (rst, synchronous) clears all valid bits and loads the default
// register values; no clearing pass is needed.
module bouncing_particle_step_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bps_pkg::ADDR_W-1:0] paddr,
  input  logic [bps_pkg::DATA_W-1:0] pwdata,
  output logic [bps_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  bps_in_if.sink                     item,
  bps_out_if.source                  result
);

  localparam int FB = FRAC_BITS;
  localparam int SW = FB + 1;                  // fractions that can reach one
  localparam logic [SW-1:0] ONE_Q = {1'b1, {FB{1'b0}}};
  localparam int SIDE1_W = 83;
  localparam int SIDE2_W = 115;

  // ---------------------------------------------------------------- config
  logic [16:0] restitution;
  logic [15:0] base_gravity;
  logic [15:0] fade_start_frame;
  logic [15:0] fade_end_frame;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution      <= bps_pkg::RESTITUTION_RST;
      base_gravity     <= bps_pkg::BASE_GRAVITY_RST;
      fade_start_frame <= bps_pkg::FADE_START_RST;
      fade_end_frame   <= bps_pkg::FADE_END_RST;
    end else if (psel && penable && pwrite) begin
      unique case (bps_pkg::reg_idx_t'(paddr[3:2]))
        bps_pkg::REG_RESTITUTION:  restitution      <= pwdata[16:0];
        bps_pkg::REG_BASE_GRAVITY: base_gravity     <= pwdata[15:0];
        bps_pkg::REG_FADE_START:   fade_start_frame <= pwdata[15:0];
        bps_pkg::REG_FADE_END:     fade_end_frame   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (bps_pkg::reg_idx_t'(paddr[3:2]))
      bps_pkg::REG_RESTITUTION:  prdata = {15'd0, restitution};
      bps_pkg::REG_BASE_GRAVITY: prdata = {16'd0, base_gravity};
      bps_pkg::REG_FADE_START:   prdata = {16'd0, fade_start_frame};
      bps_pkg::REG_FADE_END:     prdata = {16'd0, fade_end_frame};
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- stage ready
  logic rdy_p0, rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
  logic rdy_s7, rdy_s8, rdy_s9;
  logic d1_in_ready, d2_in_ready;

  // --------------------------------------------- P0: fade window classify
  logic               p0_valid;
  logic signed [31:0] p0_h, p0_v;
  logic [16:0]        p0_ratio;
  logic               p0_zero, p0_full;
  logic [15:0]        p0_num, p0_den;

  assign rdy_p0     = !p0_valid || d1_in_ready;
  assign item.ready = rdy_p0;

  always_ff @(posedge clk) begin
    if (rst) p0_valid <= 1'b0;
    else if (rdy_p0) p0_valid <= item.valid;
  end

  always_ff @(posedge clk) begin
    if (rdy_p0) begin
      p0_h     <= item.height;
      p0_v     <= item.velocity;
      p0_ratio <= item.time_ratio;
      // past the window wins over before it (reversed window case)
      p0_zero  <= item.frame_number >= fade_end_frame;
      p0_full  <= item.frame_number <= fade_start_frame;
      p0_num   <= fade_end_frame - item.frame_number;
      p0_den   <= fade_end_frame - fade_start_frame;
    end
  end

  // ------------------------------------------------ fade divider: u = n/d
  logic               d1_valid;
  logic [FB-1:0]      d1_u;
  logic [SIDE1_W-1:0] side1_in, side1_out;

  assign side1_in = {p0_h, p0_v, p0_ratio, p0_zero, p0_full};

  bps_div #(
    .DEN_W(16), .QBITS(FB), .SIDE_W(SIDE1_W)
  ) u_fade_div (
    .clk, .rst,
    .in_valid(p0_valid), .in_ready(d1_in_ready),
    .in_rem(p0_num), .in_den(p0_den), .in_side(side1_in),
    .out_valid(d1_valid), .out_ready(rdy_s1),
    .out_quo(d1_u), .out_side(side1_out)
  );

  logic signed [31:0] d1_h, d1_v;
  logic [16:0]        d1_ratio;
  logic               d1_zero, d1_full;

  assign {d1_h, d1_v, d1_ratio, d1_zero, d1_full} = side1_out;

  // ------------------------------------------- S1: u^2, velocity * ratio
  logic               s1_valid;
  logic [FB-1:0]      s1_u, s1_u2;
  logic signed [49:0] s1_p;
  logic signed [31:0] s1_h, s1_v;
  logic [16:0]        s1_ratio;
  logic               s1_zero, s1_full;
  logic [2*FB-1:0]    uu_c;
  logic signed [49:0] p_c;

  assign uu_c   = {{FB{1'b0}}, d1_u} * {{FB{1'b0}}, d1_u};
  assign p_c    = d1_v * $signed({1'b0, d1_ratio});
  assign rdy_s1 = !s1_valid || rdy_s2;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (rdy_s1) s1_valid <= d1_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy_s1) begin
      s1_u     <= d1_u;
      s1_u2    <= uu_c[2*FB-1:FB];
      s1_p     <= p_c;
      s1_h     <= d1_h;
      s1_v     <= d1_v;
      s1_ratio <= d1_ratio;
      s1_zero  <= d1_zero;
      s1_full  <= d1_full;
    end
  end

  // ----------------------------- S2: smoothstep, |v*ratio| scaled by 1/8
  logic               s2_valid;
  logic [SW-1:0]      s2_s;
  logic [28:0]        s2_y;
  logic               s2_neg;
  logic signed [31:0] s2_h, s2_v;
  logic [16:0]        s2_ratio;
  logic [FB+1:0]      poly_c;
  logic [2*FB+1:0]    sm_c;
  logic [49:0]        pa_c;

  assign poly_c = {2'b11, {FB{1'b0}}} - {1'b0, s1_u, 1'b0};   // 3 - 2u
  assign sm_c   = {{(FB+2){1'b0}}, s1_u2} * {{FB{1'b0}}, poly_c};
  assign pa_c   = s1_p[49] ? 50'(-s1_p) : 50'(s1_p);
  assign rdy_s2 = !s2_valid || rdy_s3;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (rdy_s2) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy_s2) begin
      if (s1_zero)      s2_s <= '0;
      else if (s1_full) s2_s <= ONE_Q;
      else              s2_s <= sm_c[2*FB:FB];
      s2_y     <= pa_c[47:19];      // |p| / 2^16 / 8, magnitude below 2^48
      s2_neg   <= s1_p[49];
      s2_h     <= s1_h;
      s2_v     <= s1_v;
      s2_ratio <= s1_ratio;
    end
  end

  // ------------------------------- S3: gravity, reciprocal multiply by 25
  logic               s3_valid;
  logic [15:0]        s3_g;
  logic [24:0]        s3_q0;
  logic [28:0]        s3_y;
  logic               s3_neg;
  logic signed [31:0] s3_h, s3_v;
  logic [16:0]        s3_ratio;
  logic [FB+16:0]     g_prod_c;
  logic [59:0]        qm_c;

  assign g_prod_c = (FB+17)'(base_gravity) * (FB+17)'(s2_s);
  assign qm_c     = 60'(s2_y) * 60'(bps_pkg::RECIP25);
  assign rdy_s3   = !s3_valid || rdy_s4;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (rdy_s3) s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy_s3) begin
      s3_g     <= g_prod_c[FB+15:FB];
      s3_q0    <= qm_c[59:35];
      s3_y     <= s2_y;
      s3_neg   <= s2_neg;
      s3_h     <= s2_h;
      s3_v     <= s2_v;
      s3_ratio <= s2_ratio;
    end
  end

  // ------------------------ S4: g*ratio, quotient correction and sign
  logic               s4_valid;
  logic [16:0]        s4_gr;
  logic signed [26:0] s4_qs;
  logic [15:0]        s4_g;
  logic signed [31:0] s4_h, s4_v;
  logic [32:0]        gr_prod_c;
  logic [29:0]        q25_c, rem_c;
  logic [25:0]        q_c;

  assign gr_prod_c = 33'(s3_g) * 33'(s3_ratio);
  assign q25_c     = ({5'd0, s3_q0} << 4) + ({5'd0, s3_q0} << 3) + {5'd0, s3_q0};
  assign rem_c     = {1'b0, s3_y} - q25_c;
  assign q_c       = {1'b0, s3_q0} + 26'(rem_c >= 30'd25);
  assign rdy_s4    = !s4_valid || rdy_s5;

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (rdy_s4) s4_valid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy_s4) begin
      s4_gr <= gr_prod_c[32:16];
      s4_qs <= s3_neg ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
      s4_g  <= s3_g;
      s4_h  <= s3_h;
      s4_v  <= s3_v;
    end
  end

  // ----------------------------------------- S5: integrated h1 and v1
  logic               s5_valid;
  logic signed [31:0] s5_h1, s5_v1, s5_h;
  logic [15:0]        s5_g;
  logic signed [33:0] hsum_c, vdif_c;

  assign hsum_c = 34'(s4_h) + 34'(s4_qs);
  assign vdif_c = 34'(s4_v) - $signed({17'd0, s4_gr});
  assign rdy_s5 = !s5_valid || rdy_s6;

  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else if (rdy_s5) s5_valid <= s4_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy_s5) begin
      s5_h1 <= bps_pkg::sat32(52'(hsum_c));
      s5_v1 <= bps_pkg::sat32(52'(vdif_c));
      s5_h  <= s4_h;
      s5_g  <= s4_g;
    end
  end

  // -------------- S6: ground crossing, impact fraction setup, new height
  logic               s6_valid;
  logic [31:0]        s6_rem, s6_den;
  logic signed [31:0] s6_h1, s6_v1, s6_nh;
  logic [15:0]        s6_g;
  logic               s6_bnc, s6_rz, s6_ro;
  logic signed [33:0] d_c, mh_c;
  logic signed [51:0] nh_prod_c;

  assign d_c       = 34'(s5_h) - 34'(s5_h1);
  assign mh_c      = -34'(s5_h1);
  assign nh_prod_c = mh_c * $signed({1'b0, restitution});
  assign rdy_s6    = !s6_valid || d2_in_ready;

  always_ff @(posedge clk) begin
    if (rst) s6_valid <= 1'b0;
    else if (rdy_s6) s6_valid <= s5_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy_s6) begin
      s6_rem <= s5_h;
      s6_den <= d_c[31:0];
      s6_h1  <= s5_h1;
      s6_v1  <= s5_v1;
      s6_g   <= s5_g;
      s6_bnc <= s5_h1 < 0;
      // started at or under ground, or never fell: no time before impact
      s6_rz  <= (d_c <= 0) || (s5_h <= 0);
      s6_ro  <= 34'(s5_h) >= d_c;
      s6_nh  <= bps_pkg::sat32(nh_prod_c >>> 16);
    end
  end

  // ------------------------------------- impact fraction divider: r = h/d
  logic               d2_valid;
  logic [FB-1:0]      d2_q;
  logic [SIDE2_W-1:0] side2_in, side2_out;

  assign side2_in = {s6_h1, s6_v1, s6_g, s6_bnc, s6_rz, s6_ro, s6_nh};

  bps_div #(
    .DEN_W(32), .QBITS(FB), .SIDE_W(SIDE2_W)
  ) u_impact_div (
    .clk, .rst,
    .in_valid(s6_valid), .in_ready(d2_in_ready),
    .in_rem(s6_rem), .in_den(s6_den), .in_side(side2_in),
    .out_valid(d2_valid), .out_ready(rdy_s7),
    .out_quo(d2_q), .out_side(side2_out)
  );

  logic signed [31:0] d2_h1, d2_v1, d2_nh;
  logic [15:0]        d2_g;
  logic               d2_bnc, d2_rz, d2_ro;

  assign {d2_h1, d2_v1, d2_g, d2_bnc, d2_rz, d2_ro, d2_nh} = side2_out;

  // ------------------------------- S7: gravity over the rest of the step
  logic               s7_valid;
  logic [16:0]        s7_gm;
  logic signed [31:0] s7_h1, s7_v1, s7_nh;
  logic               s7_bnc;
  logic [SW-1:0]      r_c, omr_c;
  logic [FB+17:0]     gm_prod_c;

  assign r_c       = d2_rz ? '0 : (d2_ro ? ONE_Q : {1'b0, d2_q});
  assign omr_c     = ONE_Q - r_c;
  assign gm_prod_c = {{SW{1'b0}}, d2_g, 1'b0} * {17'd0, omr_c};
  assign rdy_s7    = !s7_valid || rdy_s8;

  always_ff @(posedge clk) begin
    if (rst) s7_valid <= 1'b0;
    else if (rdy_s7) s7_valid <= d2_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy_s7) begin
      s7_gm  <= gm_prod_c[FB+16:FB];
      s7_h1  <= d2_h1;
      s7_v1  <= d2_v1;
      s7_nh  <= d2_nh;
      s7_bnc <= d2_bnc;
    end
  end

  // ----------------------------- S8: rebuilt velocity times restitution
  logic               s8_valid;
  logic signed [51:0] s8_tp;
  logic signed [31:0] s8_h1, s8_v1, s8_nh;
  logic               s8_bnc;
  logic signed [33:0] t_c;
  logic signed [51:0] tp_c;

  assign t_c    = -$signed({17'd0, s7_gm}) - 34'(s7_v1);
  assign tp_c   = t_c * $signed({1'b0, restitution});
  assign rdy_s8 = !s8_valid || rdy_s9;

  always_ff @(posedge clk) begin
    if (rst) s8_valid <= 1'b0;
    else if (rdy_s8) s8_valid <= s7_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy_s8) begin
      s8_tp  <= tp_c;
      s8_h1  <= s7_h1;
      s8_v1  <= s7_v1;
      s8_nh  <= s7_nh;
      s8_bnc <= s7_bnc;
    end
  end

  // ------------------------- S9: output register, truncate toward zero
  logic               s9_valid;
  logic signed [31:0] s9_nh, s9_nv;
  logic               s9_bnc;
  logic signed [51:0] tp_adj_c, nv_c;

  assign tp_adj_c = s8_tp + 52'sd65535;
  assign nv_c     = s8_tp[51] ? (tp_adj_c >>> 16) : (s8_tp >>> 16);
  assign rdy_s9   = !s9_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) s9_valid <= 1'b0;
    else if (rdy_s9) s9_valid <= s8_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy_s9) begin
      s9_bnc <= s8_bnc;
      if (s8_bnc) begin
        s9_nh <= s8_nh;
        s9_nv <= bps_pkg::sat32(nv_c);
      end else begin
        s9_nh <= s8_h1;
        s9_nv <= s8_v1;
      end
    end
  end

  assign result.valid        = s9_valid;
  assign result.new_height   = s9_nh;
  assign result.new_velocity = s9_nv;
  assign result.bounced      = s9_bnc;

endmodule
